[design/gf2m_au_pkg.sv]
`timescale 1ns / 1ps

package gf2m_au_pkg;

  // fixed field widths of the ports
  localparam int unsigned ELEM_W     = 8;
  localparam int unsigned DEGREE_W   = 4;
  localparam int unsigned POLY_W     = 9;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [DEGREE_W-1:0] DEGREE_RESET = 4'd8;
  localparam logic [POLY_W-1:0]   POLY_RESET   = 9'd285;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEGREE = 1'b0,
    REG_POLY   = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_EUCLID,
    ST_MUL,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    MUL_HOLD,
    MUL_START_AB,
    MUL_START_AINV,
    MUL_STEP
  } mul_op_e;

  typedef enum logic [1:0] {
    RES_HOLD,
    RES_XOR,
    RES_MUL,
    RES_UNDEF
  } res_op_e;

  typedef struct packed {
    logic    load;
    logic    euc_step;
    mul_op_e mul_op;
    res_op_e res_op;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  b_zero;
    logic  rem_zero;
    logic  gcd_one;
  } stat_t;

endpackage

[design/gf2m_au_ctrl.sv]
`timescale 1ns / 1ps

module gf2m_au_ctrl #(
  parameter int unsigned MAX_DEGREE = 8,
  localparam int unsigned MW = $clog2(MAX_DEGREE + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [MW-1:0]        degree_i,
  input  gf2m_au_pkg::stat_t   stat_i,
  output gf2m_au_pkg::cmd_t    cmd_o,
  output logic                 busy_o,
  output logic                 done_o
);

  gf2m_au_pkg::state_e state_q, state_d;
  logic [MW-1:0]       cnt_q, cnt_d;
  logic                done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gf2m_au_pkg::ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    done_d         = 1'b0;
    cmd_o.load     = 1'b0;
    cmd_o.euc_step = 1'b0;
    cmd_o.mul_op   = gf2m_au_pkg::MUL_HOLD;
    cmd_o.res_op   = gf2m_au_pkg::RES_HOLD;
    unique case (state_q)
      gf2m_au_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = gf2m_au_pkg::ST_DISPATCH;
        end
      end
      gf2m_au_pkg::ST_DISPATCH: begin
        unique case (stat_i.kind)
          gf2m_au_pkg::KIND_ADD, gf2m_au_pkg::KIND_SUB: begin
            cmd_o.res_op = gf2m_au_pkg::RES_XOR;
            done_d       = 1'b1;
            state_d      = gf2m_au_pkg::ST_IDLE;
          end
          gf2m_au_pkg::KIND_MUL: begin
            cmd_o.mul_op = gf2m_au_pkg::MUL_START_AB;
            cnt_d        = '0;
            state_d      = gf2m_au_pkg::ST_MUL;
          end
          gf2m_au_pkg::KIND_DIV: begin
            if (stat_i.b_zero) begin
              cmd_o.res_op = gf2m_au_pkg::RES_UNDEF;
              done_d       = 1'b1;
              state_d      = gf2m_au_pkg::ST_IDLE;
            end else begin
              state_d = gf2m_au_pkg::ST_EUCLID;
            end
          end
          default: state_d = gf2m_au_pkg::ST_IDLE;
        endcase
      end
      gf2m_au_pkg::ST_EUCLID: begin
        if (stat_i.rem_zero) begin
          if (stat_i.gcd_one) begin
            cmd_o.mul_op = gf2m_au_pkg::MUL_START_AINV;
            cnt_d        = '0;
            state_d      = gf2m_au_pkg::ST_MUL;
          end else begin
            cmd_o.res_op = gf2m_au_pkg::RES_UNDEF;
            done_d       = 1'b1;
            state_d      = gf2m_au_pkg::ST_IDLE;
          end
        end else begin
          cmd_o.euc_step = 1'b1;
        end
      end
      gf2m_au_pkg::ST_MUL: begin
        cmd_o.mul_op = gf2m_au_pkg::MUL_STEP;
        cnt_d        = cnt_q + MW'(1);
        if (cnt_q == degree_i - MW'(1)) begin
          state_d = gf2m_au_pkg::ST_FINISH;
        end
      end
      gf2m_au_pkg::ST_FINISH: begin
        cmd_o.res_op = gf2m_au_pkg::RES_MUL;
        done_d       = 1'b1;
        state_d      = gf2m_au_pkg::ST_IDLE;
      end
      default: state_d = gf2m_au_pkg::ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != gf2m_au_pkg::ST_IDLE);
  assign done_o = done_q;

endmodule

[design/gf2m_au_dp.sv]
`timescale 1ns / 1ps

module gf2m_au_dp #(
  parameter int unsigned MAX_DEGREE = 8,
  localparam int unsigned W  = MAX_DEGREE,
  localparam int unsigned DW = $clog2(MAX_DEGREE + 1)
) (
  input  logic                                clk_i,
  input  gf2m_au_pkg::cmd_t                   cmd_i,
  input  gf2m_au_pkg::kind_e                  kind_i,
  input  logic [gf2m_au_pkg::ELEM_W-1:0]      operand_a_i,
  input  logic [gf2m_au_pkg::ELEM_W-1:0]      operand_b_i,
  input  logic [W-1:0]                        mask_i,
  input  logic [W-1:0]                        poly_i,
  output gf2m_au_pkg::stat_t                  stat_o,
  output logic [gf2m_au_pkg::ELEM_W-1:0]      result_value_o,
  output logic                                undefined_flag_o
);

  // highest set bit, zero for an all-zero word
  function automatic logic [DW-1:0] deg_of(input logic [W:0] v);
    logic [DW-1:0] d;
    d = '0;
    for (int i = 0; i <= int'(W); i++) begin
      if (v[i]) d = DW'(i);
    end
    return d;
  endfunction

  gf2m_au_pkg::kind_e kind_q;
  logic [W-1:0] a_q, b_q;
  logic [W:0]   ra_q, rb_q, ta_q, tb_q;
  logic [W-1:0] p_q, mc_q, mr_q;
  logic [gf2m_au_pkg::ELEM_W-1:0] res_q;
  logic         undef_q;

  logic [W+gf2m_au_pkg::ELEM_W-1:0] ext_a, ext_b, ext_x, ext_p;
  logic [W-1:0] a_in, b_in, top_bit, p_next, xor_res;
  logic [W:0]   fpoly;
  logic [DW-1:0] deg_a, deg_b, shamt;
  logic         reduce;

  assign ext_a = {{W{1'b0}}, operand_a_i};
  assign ext_b = {{W{1'b0}}, operand_b_i};
  assign a_in  = ext_a[W-1:0] & mask_i;
  assign b_in  = ext_b[W-1:0] & mask_i;

  // X^m plus the low m polynomial bits
  assign fpoly = ({mask_i, 1'b1} ^ {1'b0, mask_i}) | {1'b0, poly_i};

  assign deg_a  = deg_of(ra_q);
  assign deg_b  = deg_of(rb_q);
  assign shamt  = deg_a - deg_b;
  assign reduce = (ra_q != '0) && (deg_a >= deg_b);

  // msb-first shift-and-add with reduction at bit m-1
  assign top_bit = mask_i & ~(mask_i >> 1);
  assign p_next  = ((p_q << 1) & mask_i)
                 ^ (((p_q & top_bit) != '0) ? poly_i : '0)
                 ^ (((mr_q & top_bit) != '0) ? mc_q : '0);

  assign xor_res = a_q ^ b_q;
  assign ext_x   = {{gf2m_au_pkg::ELEM_W{1'b0}}, xor_res};
  assign ext_p   = {{gf2m_au_pkg::ELEM_W{1'b0}}, p_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      a_q    <= a_in;
      b_q    <= b_in;
      ra_q   <= fpoly;
      rb_q   <= {1'b0, b_in};
      ta_q   <= '0;
      tb_q   <= (W+1)'(1);
    end else if (cmd_i.euc_step) begin
      if (reduce) begin
        ra_q <= ra_q ^ (rb_q << shamt);
        ta_q <= ta_q ^ (tb_q << shamt);
      end else begin
        ra_q <= rb_q;
        rb_q <= ra_q;
        ta_q <= tb_q;
        tb_q <= ta_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.mul_op)
      gf2m_au_pkg::MUL_HOLD: ;
      gf2m_au_pkg::MUL_START_AB: begin
        p_q  <= '0;
        mc_q <= a_q;
        mr_q <= b_q;
      end
      gf2m_au_pkg::MUL_START_AINV: begin
        p_q  <= '0;
        mc_q <= a_q;
        mr_q <= ta_q[W-1:0];
      end
      gf2m_au_pkg::MUL_STEP: begin
        p_q  <= p_next;
        mr_q <= mr_q << 1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.res_op)
      gf2m_au_pkg::RES_HOLD: ;
      gf2m_au_pkg::RES_XOR: begin
        res_q   <= ext_x[gf2m_au_pkg::ELEM_W-1:0];
        undef_q <= 1'b0;
      end
      gf2m_au_pkg::RES_MUL: begin
        res_q   <= ext_p[gf2m_au_pkg::ELEM_W-1:0];
        undef_q <= 1'b0;
      end
      gf2m_au_pkg::RES_UNDEF: begin
        res_q   <= '0;
        undef_q <= 1'b1;
      end
      default: ;
    endcase
  end

  assign stat_o.kind     = kind_q;
  assign stat_o.b_zero   = (b_q == '0);
  assign stat_o.rem_zero = (rb_q == '0);
  assign stat_o.gcd_one  = (ra_q == (W+1)'(1));

  assign result_value_o   = res_q;
  assign undefined_flag_o = undef_q;

endmodule

[design/gf2m_arith_unit.sv]
`timescale 1ns / 1ps

// GF(2^m) add, subtract, multiply and divide, one request at a time. A request
// is taken on a rising edge with start high and busy low; its result appears on
// result_value_o / undefined_flag_o, marked by result_valid_o for exactly one
// cycle, and the receiver cannot stall it, so capture it on that cycle. Add and
// subtract are settled in the dispatch state; multiply runs one bit-serial
// shift-and-reduce step per bit, then a finish state; divide is flagged
// undefined in the dispatch state when the divisor is zero, otherwise runs one
// pass of a binary extended Euclid unit (one shift-xor or swap per cycle)
// followed by the multiply. A divide whose divisor has no inverse under the
// programmed polynomial returns zero with undefined_flag_o set. Configuration
// writes are always ready and must only be issued while the unit is idle.

module gf2m_arith_unit #(
  parameter int unsigned MAX_DEGREE = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // request channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           kind_i,
  input  logic [gf2m_au_pkg::ELEM_W-1:0]       operand_a_i,
  input  logic [gf2m_au_pkg::ELEM_W-1:0]       operand_b_i,
  // result strobe
  output logic                                 result_valid_o,
  output logic [gf2m_au_pkg::ELEM_W-1:0]       result_value_o,
  output logic                                 undefined_flag_o,
  // configuration write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [gf2m_au_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [gf2m_au_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned W  = MAX_DEGREE;
  localparam int unsigned MW = $clog2(MAX_DEGREE + 1);

  logic [gf2m_au_pkg::DEGREE_W-1:0] degree_q;
  logic [gf2m_au_pkg::POLY_W-1:0]   poly_q;

  logic [MW-1:0]                      eff_degree;
  logic [W-1:0]                       mask;
  logic [W+gf2m_au_pkg::POLY_W-1:0]   poly_ext;
  logic [W-1:0]                       poly_low;

  gf2m_au_pkg::cmd_t  cmd;
  gf2m_au_pkg::stat_t stat;

  // config registers, writes never stall
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= gf2m_au_pkg::DEGREE_RESET;
      poly_q   <= gf2m_au_pkg::POLY_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (gf2m_au_pkg::cfg_reg_e'(cfg_index_i))
        gf2m_au_pkg::REG_DEGREE: degree_q <= cfg_data_i[gf2m_au_pkg::DEGREE_W-1:0];
        gf2m_au_pkg::REG_POLY:   poly_q   <= cfg_data_i[gf2m_au_pkg::POLY_W-1:0];
        default: ;
      endcase
    end
  end

  // degree zero runs as one, anything above the build limit as the limit
  always_comb begin
    if (degree_q == '0) begin
      eff_degree = MW'(1);
    end else if (int'(degree_q) > int'(W)) begin
      eff_degree = MW'(W);
    end else begin
      eff_degree = MW'(degree_q);
    end
  end

  // low m bits set
  always_comb begin
    for (int i = 0; i < int'(W); i++) begin
      mask[i] = (i < int'(eff_degree));
    end
  end

  // leading term is implied, so bit m and above of the register are dropped
  assign poly_ext = {{W{1'b0}}, poly_q};
  assign poly_low = poly_ext[W-1:0] & mask;

  gf2m_au_ctrl #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .degree_i (eff_degree),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (result_valid_o)
  );

  gf2m_au_dp #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_dp (
    .clk_i            (clk_i),
    .cmd_i            (cmd),
    .kind_i           (gf2m_au_pkg::kind_e'(kind_i)),
    .operand_a_i      (operand_a_i),
    .operand_b_i      (operand_b_i),
    .mask_i           (mask),
    .poly_i           (poly_low),
    .stat_o           (stat),
    .result_value_o   (result_value_o),
    .undefined_flag_o (undefined_flag_o)
  );

`ifndef SYNTH
  // strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  // unit is already free when its result shows
  a_free_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("busy while result is presented");

  // an accepted request makes the unit busy
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !result_valid_o))
    else $error("request accepted without going busy");

  // undefined results are zero
  a_undef_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && undefined_flag_o) |-> (result_value_o == '0))
    else $error("undefined result carries a nonzero value");
`endif

endmodule
